// ===== rtl/envelope_compressor_defines.svh =====
// Assertion macros shared by the envelope compressor RTL.
// Included by files that carry concurrent assertions; needs no package.
`ifndef ENVELOPE_COMPRESSOR_DEFINES_SVH
`define ENVELOPE_COMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ENVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ENVC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/envc_pkg.sv =====
// Shared types, constants and the microcode table of the envelope compressor.
// Used by envc_seq, envc_dp and envelope_compressor; depends on nothing.
package envc_pkg;

	localparam int SAMPLE_W          = 16;
	localparam int THR_W             = 15;
	localparam int RATIO_W           = 10;
	localparam int COEF_W            = 16;
	localparam int GAIN_W            = 17;
	localparam int CFG_DATA_W        = 16;
	localparam int CFG_IDX_W         = 2;
	localparam int ENV_FRAC_BITS_DEF = 23;

	localparam logic [THR_W-1:0]   THR_RESET     = 15'd8231;
	localparam logic [RATIO_W-1:0] RATIO_RESET   = 10'd64;
	localparam logic [COEF_W-1:0]  ATTACK_RESET  = 16'd66;
	localparam logic [COEF_W-1:0]  RELEASE_RESET = 16'd6554;
	localparam logic [RATIO_W-1:0] RATIO_MIN     = 10'd16;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_THRESHOLD = 2'd0;
	localparam reg_idx_t REG_RATIO     = 2'd1;
	localparam reg_idx_t REG_ATTACK    = 2'd2;
	localparam reg_idx_t REG_RELEASE   = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] in_sample;
		logic                       block_last;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_sample;
		logic                       block_last_out;
		logic                       compressing;
	} out_item_t;

	typedef struct packed {
		logic [THR_W-1:0]   threshold_level;
		logic [RATIO_W-1:0] ratio_sixteenths;
		logic [COEF_W-1:0]  attack_coeff;
		logic [COEF_W-1:0]  release_coeff;
	} cfg_t;

	typedef logic [3:0] op_t;
	localparam op_t OP_NOP   = 4'd0;
	localparam op_t OP_LOAD  = 4'd1;
	localparam op_t OP_MUL   = 4'd2;
	localparam op_t OP_ENV   = 4'd3;
	localparam op_t OP_CMP   = 4'd4;
	localparam op_t OP_DIV_R = 4'd5;
	localparam op_t OP_NUM   = 4'd6;
	localparam op_t OP_DIV_E = 4'd7;
	localparam op_t OP_GAIN  = 4'd8;
	localparam op_t OP_OUT   = 4'd9;

	typedef logic [2:0] cond_t;
	localparam cond_t COND_NEXT     = 3'd0;
	localparam cond_t COND_WAIT_IN  = 3'd1;
	localparam cond_t COND_LOOP     = 3'd2;
	localparam cond_t COND_PASS     = 3'd3;
	localparam cond_t COND_WAIT_OUT = 3'd4;

	typedef logic [1:0] lim_t;
	localparam lim_t LIM_NONE = 2'd0;
	localparam lim_t LIM_MUL  = 2'd1;
	localparam lim_t LIM_DIV1 = 2'd2;
	localparam lim_t LIM_DIV2 = 2'd3;

	typedef logic [3:0] upc_t;
	localparam upc_t UPC_IDLE = 4'd0;
	localparam upc_t UPC_MUL  = 4'd1;
	localparam upc_t UPC_ENV  = 4'd2;
	localparam upc_t UPC_CMP  = 4'd3;
	localparam upc_t UPC_DIVR = 4'd4;
	localparam upc_t UPC_NUM  = 4'd5;
	localparam upc_t UPC_DIVE = 4'd6;
	localparam upc_t UPC_GAIN = 4'd7;
	localparam upc_t UPC_OUT  = 4'd8;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
		lim_t  lim;
	} ucode_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	typedef struct packed {
		logic over;
		logic out_busy;
	} status_t;

	function automatic ucode_t envc_ucode(input upc_t addr);
		ucode_t w;
		unique case (addr)
			UPC_IDLE: w = '{op: OP_LOAD,  cond: COND_WAIT_IN,  target: UPC_IDLE, lim: LIM_NONE};
			UPC_MUL:  w = '{op: OP_MUL,   cond: COND_LOOP,     target: UPC_IDLE, lim: LIM_MUL};
			UPC_ENV:  w = '{op: OP_ENV,   cond: COND_NEXT,     target: UPC_IDLE, lim: LIM_NONE};
			UPC_CMP:  w = '{op: OP_CMP,   cond: COND_PASS,     target: UPC_OUT,  lim: LIM_NONE};
			UPC_DIVR: w = '{op: OP_DIV_R, cond: COND_LOOP,     target: UPC_IDLE, lim: LIM_DIV1};
			UPC_NUM:  w = '{op: OP_NUM,   cond: COND_NEXT,     target: UPC_IDLE, lim: LIM_NONE};
			UPC_DIVE: w = '{op: OP_DIV_E, cond: COND_LOOP,     target: UPC_IDLE, lim: LIM_DIV2};
			UPC_GAIN: w = '{op: OP_GAIN,  cond: COND_NEXT,     target: UPC_IDLE, lim: LIM_NONE};
			UPC_OUT:  w = '{op: OP_OUT,   cond: COND_WAIT_OUT, target: UPC_IDLE, lim: LIM_NONE};
			default:  w = '{op: OP_NOP,   cond: COND_WAIT_OUT, target: UPC_IDLE, lim: LIM_NONE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/envc_seq.sv =====
// Microcode sequencer: program counter, loop counter and branch logic.
// Reads the control table from envc_pkg and drives envc_dp through ctrl_t.
module envc_seq #(
	parameter int ENVELOPE_FRAC_BITS = envc_pkg::ENV_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  envc_pkg::status_t status,
	output logic              in_ready,
	output envc_pkg::ctrl_t   ctrl
);
	import envc_pkg::*;

	localparam int EW = ENVELOPE_FRAC_BITS + 1;
	localparam int QW = (EW > GAIN_W) ? EW : GAIN_W;
	localparam int CW = $clog2(QW);

	upc_t            upc_q;
	upc_t            upc_nxt;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_nxt;
	logic [CW-1:0]   limit;
	ucode_t          word;

	assign word     = envc_ucode(upc_q);
	assign in_ready = (word.cond == COND_WAIT_IN);

	always_comb begin
		unique case (word.lim)
			LIM_MUL:  limit = CW'(COEF_W - 1);
			LIM_DIV1: limit = CW'(EW - 1);
			LIM_DIV2: limit = CW'(GAIN_W - 1);
			LIM_NONE: limit = '0;
		endcase
	end

	always_comb begin
		upc_nxt = upc_q + 4'd1;
		cnt_nxt = '0;
		ctrl.op = word.op;
		unique case (word.cond)
			COND_NEXT: begin
			end
			COND_WAIT_IN: begin
				if (!in_valid) begin
					upc_nxt = upc_q;
					ctrl.op = OP_NOP;
				end
			end
			COND_LOOP: begin
				if (cnt_q != limit) begin
					upc_nxt = upc_q;
					cnt_nxt = cnt_q + CW'(1);
				end
			end
			COND_PASS: begin
				if (!status.over) begin
					upc_nxt = word.target;
				end
			end
			COND_WAIT_OUT: begin
				if (status.out_busy) begin
					upc_nxt = upc_q;
					ctrl.op = OP_NOP;
				end else begin
					upc_nxt = word.target;
				end
			end
			default: begin
				upc_nxt = UPC_IDLE;
				ctrl.op = OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
			cnt_q <= '0;
		end else begin
			upc_q <= upc_nxt;
			cnt_q <= cnt_nxt;
		end
	end

endmodule

// ===== rtl/envc_dp.sv =====
// Datapath: envelope register, serial multiplier, serial divider, gain multiply
// and output register. Controlled by envc_seq; types from envc_pkg.
module envc_dp #(
	parameter int ENVELOPE_FRAC_BITS = envc_pkg::ENV_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  envc_pkg::cfg_t      cfg,
	input  envc_pkg::ctrl_t     ctrl,
	input  envc_pkg::in_item_t  in_item,
	output envc_pkg::status_t   status,
	output logic                out_valid,
	input  logic                out_ready,
	output envc_pkg::out_item_t out_item
);
	import envc_pkg::*;

	localparam int EW  = ENVELOPE_FRAC_BITS + 1;
	localparam int DW  = EW + 1;
	localparam int AW  = EW + COEF_W + 1;
	localparam int QW  = (EW > GAIN_W) ? EW : GAIN_W;
	localparam int SH  = ENVELOPE_FRAC_BITS - (SAMPLE_W - 1);
	localparam int PW  = SAMPLE_W + GAIN_W;

	logic [EW-1:0]            env_q;
	logic [SAMPLE_W-1:0]      sample_q;
	logic                     last_q;
	logic [SAMPLE_W-1:0]      mag_q;
	logic signed [DW-1:0]     diff_q;
	logic [COEF_W-1:0]        coef_q;
	logic signed [AW-1:0]     acc_q;
	logic [DW-1:0]            rem_q;
	logic [QW-1:0]            quo_q;
	logic [PW-1:0]            prod_q;
	logic                     comp_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic [SAMPLE_W-1:0]      raw;
	logic [SAMPLE_W-1:0]      mag_in;
	logic [EW-1:0]            mag_e;
	logic [EW-1:0]            thr_e;
	logic [EW-1:0]            over_amt;
	logic [EW-1:0]            over_sh;
	logic [EW-1:0]            num;
	logic signed [DW-1:0]     env_sum;
	logic [RATIO_W-1:0]       ratio_eff;
	logic [EW-1:0]            divisor;
	logic [DW:0]              trial;
	logic                     fits;
	logic [SAMPLE_W-1:0]      scaled;
	logic [SAMPLE_W-1:0]      signed_res;

	assign raw       = in_item.in_sample;
	assign mag_in    = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
	assign mag_e     = EW'(mag_in) << SH;
	assign thr_e     = EW'(cfg.threshold_level) << (ENVELOPE_FRAC_BITS - THR_W);
	assign over_amt  = env_q - thr_e;
	assign over_sh   = over_amt << 4;
	assign num       = thr_e + quo_q[EW-1:0];
	assign env_sum   = $signed({1'b0, env_q}) + $signed(acc_q[AW-1:COEF_W]);
	assign ratio_eff = (cfg.ratio_sixteenths < RATIO_MIN) ? RATIO_MIN : cfg.ratio_sixteenths;
	assign divisor   = (ctrl.op == OP_DIV_R) ? EW'(ratio_eff) : env_q;
	assign trial     = {rem_q, quo_q[QW-1]};
	assign fits      = (trial >= (DW+1)'(divisor));
	assign scaled    = prod_q[SAMPLE_W+GAIN_W-2:GAIN_W-1];
	assign signed_res = sample_q[SAMPLE_W-1] ? (~scaled + SAMPLE_W'(1)) : scaled;

	assign status.over     = (env_q > thr_e);
	assign status.out_busy = out_valid_q & ~out_ready;
	assign out_valid       = out_valid_q;
	assign out_item        = out_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				sample_q <= raw;
				last_q   <= in_item.block_last;
				mag_q    <= mag_in;
				diff_q   <= $signed({1'b0, mag_e}) - $signed({1'b0, env_q});
				coef_q   <= (mag_e > env_q) ? cfg.attack_coeff : cfg.release_coeff;
				acc_q    <= '0;
			end
			OP_MUL: begin
				acc_q  <= (acc_q <<< 1) + (coef_q[COEF_W-1] ? AW'(diff_q) : AW'(0));
				coef_q <= coef_q << 1;
			end
			OP_CMP: begin
				comp_q <= status.over;
				rem_q  <= DW'(over_amt >> (EW - 4));
				quo_q  <= QW'(over_sh) << (QW - EW);
			end
			OP_DIV_R, OP_DIV_E: begin
				rem_q <= fits ? DW'(trial - (DW+1)'(divisor)) : DW'(trial);
				quo_q <= {quo_q[QW-2:0], fits};
			end
			OP_NUM: begin
				rem_q <= DW'(num >> 1);
				quo_q <= QW'({num[0], {(GAIN_W-1){1'b0}}}) << (QW - GAIN_W);
			end
			OP_GAIN: begin
				prod_q <= PW'(mag_q) * PW'(quo_q[GAIN_W-1:0]);
			end
			OP_OUT: begin
				out_q.out_sample     <= comp_q ? signed_res : sample_q;
				out_q.block_last_out <= last_q;
				out_q.compressing    <= comp_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (ctrl.op == OP_ENV) begin
			env_q <= env_sum[EW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/envelope_compressor.sv =====
// Envelope compressor: one Q1.15 sample request in, one compressed sample request out.
// Input and output are valid/ready channels; the four settings are written through
// a plain write port (cfg_we, cfg_index, cfg_data) and should take effect on the next
// request, which the block does not enforce. A peak envelope (Q1.ENVELOPE_FRAC_BITS)
// follows each sample's magnitude; above the threshold the sample is scaled by a gain
// no larger than one. A request is taken only when the sequencer is back at its first
// step. From accept to the result register, a sample below threshold passes a 16-step
// serial envelope multiply, the envelope update and the threshold compare; one above
// adds a restoring division by the ratio, a 17-step gain division and the gain multiply.
// The sequencer then returns to its first step before the next request is taken.
// The result waits in an output register; a stalled receiver holds the sequencer at its
// last step, so at most one finished result and one request in work exist at a time.
// Reset clears the envelope, the output valid, the sequencer and restores the default
// settings: threshold 8231, ratio 4:1, attack 66, release 6554.
`include "envelope_compressor_defines.svh"

module envelope_compressor #(
	parameter int ENVELOPE_FRAC_BITS = envc_pkg::ENV_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  envc_pkg::in_item_t                   in_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output envc_pkg::out_item_t                  out_item,
	input  logic                                 cfg_we,
	input  logic [envc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [envc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import envc_pkg::*;

	cfg_t    cfg_q;
	ctrl_t   ctrl;
	status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_level  <= THR_RESET;
			cfg_q.ratio_sixteenths <= RATIO_RESET;
			cfg_q.attack_coeff     <= ATTACK_RESET;
			cfg_q.release_coeff    <= RELEASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold_level  <= cfg_data[THR_W-1:0];
				REG_RATIO:     cfg_q.ratio_sixteenths <= cfg_data[RATIO_W-1:0];
				REG_ATTACK:    cfg_q.attack_coeff     <= cfg_data[COEF_W-1:0];
				REG_RELEASE:   cfg_q.release_coeff    <= cfg_data[COEF_W-1:0];
			endcase
		end
	end

	envc_seq #(
		.ENVELOPE_FRAC_BITS(ENVELOPE_FRAC_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	envc_dp #(
		.ENVELOPE_FRAC_BITS(ENVELOPE_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ctrl      (ctrl),
		.in_item   (in_item),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	`ENVC_ASSERT_IMP(a_out_slot_free, clk, arst_n, ctrl.op == OP_OUT, !out_valid || out_ready, "result written while the output register still held an unread result")
	`ENVC_ASSERT_NXT(a_out_loaded, clk, arst_n, ctrl.op == OP_OUT, out_valid, "result write did not raise out_valid")
	`ENVC_ASSERT_NXT(a_one_in_work, clk, arst_n, in_valid && in_ready, !in_ready, "sequencer took a second request before finishing the first")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for envelope_compressor: directed and random sample
// requests, checked field by field against an envelope and gain predictor.
// Depends on envc_pkg and the envelope_compressor RTL only.
module testbench;
	import envc_pkg::*;

	localparam int ENV_FRAC   = ENV_FRAC_BITS_DEF;
	localparam int WATCHDOG   = 4000;
	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 190;

	typedef enum {ROW_SETTINGS, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		logic [15:0]     thr;
		logic [15:0]     ratio;
		logic [15:0]     attack;
		logic [15:0]     rel;
		in_item_t        item;
		bit              known;
		logic            compressing;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_item = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_item;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [ENV_FRAC:0]    envelope_q;
	logic [THR_W-1:0]     thr_q;
	logic [RATIO_W-1:0]   ratio_q;
	logic [COEF_W-1:0]    attack_q;
	logic [COEF_W-1:0]    release_q;

	out_item_t            expected_samples[$];
	stim_row_t            directed_rows[$];
	int                   errors = 0;
	int                   samples_sent = 0;
	int                   results_checked = 0;
	int                   compressed_seen = 0;
	int                   tx_idle_pct = 0;
	int                   rx_idle_pct = 0;
	int                   rx_long_hold = 0;
	int                   rx_gap = 0;
	int                   stall_cycles = 0;

	envelope_compressor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	function automatic out_item_t compress_sample(input in_item_t item);
		logic [63:0] raw, mag, mag_e, thr_e, coeff, env, ratio, num, gain, scaled;
		logic        neg;
		out_item_t   result;
		raw = {48'd0, item.in_sample};
		neg = item.in_sample[SAMPLE_W-1];
		mag = neg ? (64'd65536 - raw) : raw;
		mag_e = mag << (ENV_FRAC - (SAMPLE_W - 1));
		thr_e = 64'(thr_q) << (ENV_FRAC - THR_W);
		env = 64'(envelope_q);
		coeff = (mag_e > env) ? 64'(attack_q) : 64'(release_q);
		env = (env * (64'd65536 - coeff) + mag_e * coeff) >> 16;
		envelope_q = env[ENV_FRAC:0];
		result.out_sample = item.in_sample;
		result.block_last_out = item.block_last;
		result.compressing = 1'b0;
		if (env > thr_e) begin
			ratio = (ratio_q < RATIO_MIN) ? 64'(RATIO_MIN) : 64'(ratio_q);
			num = thr_e + ((env - thr_e) * 16) / ratio;
			gain = (num << 16) / env;
			scaled = (mag * gain) >> 16;
			result.out_sample = neg ? 16'(-scaled) : 16'(scaled);
			result.compressing = 1'b1;
		end
		return result;
	endfunction

	function automatic stim_row_t setting_row(input logic [15:0] thr, ratio, attack, rel);
		stim_row_t row;
		row = '{kind: ROW_SETTINGS, thr: thr, ratio: ratio, attack: attack, rel: rel,
			item: '0, known: 1'b0, compressing: 1'b0};
		return row;
	endfunction

	function automatic stim_row_t sample_row(input int s, input bit last, input bit known,
			input logic comp);
		stim_row_t row;
		row = '{kind: ROW_SAMPLE, thr: '0, ratio: '0, attack: '0, rel: '0,
			item: '{in_sample: s[15:0], block_last: last}, known: known, compressing: comp};
		return row;
	endfunction

	function automatic logic [15:0] pick_setting(input logic [15:0] low_val, high_val,
			input int typ_lo, input int typ_hi);
		case ($urandom_range(0, 5))
			0: return low_val;
			1: return high_val;
			2, 3: return 16'($urandom_range(typ_lo, typ_hi));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic write_settings(input logic [15:0] thr, ratio, attack, rel);
		cfg_we <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= REG_RATIO;
		cfg_data <= ratio;
		@(posedge clk);
		cfg_index <= REG_ATTACK;
		cfg_data <= attack;
		@(posedge clk);
		cfg_index <= REG_RELEASE;
		cfg_data <= rel;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_q = thr[THR_W-1:0];
		ratio_q = ratio[RATIO_W-1:0];
		attack_q = attack;
		release_q = rel;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
	endtask

	task automatic offer_sample(input in_item_t item, input bit known, input logic comp);
		out_item_t predicted;
		in_valid <= 1'b1;
		in_item <= item;
		do @(posedge clk); while (!in_ready);
		predicted = compress_sample(item);
		if (known)
			predicted = '{out_sample: item.in_sample, block_last_out: item.block_last,
				compressing: comp};
		expected_samples = {expected_samples, predicted};
		samples_sent++;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_long_hold > 0) begin
				rx_long_hold--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < rx_idle_pct)
					rx_gap = $urandom_range(1, 10);
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (out_item.compressing === 1'b1)
				compressed_seen++;
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, out_item);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				if (out_item.out_sample !== want.out_sample) begin
					$display("%0t: out_sample expected %h actual %h", $time,
						want.out_sample, out_item.out_sample);
					errors++;
				end
				if (out_item.block_last_out !== want.block_last_out) begin
					$display("%0t: block_last_out expected %b actual %b", $time,
						want.block_last_out, out_item.block_last_out);
					errors++;
				end
				if (out_item.compressing !== want.compressing) begin
					$display("%0t: compressing expected %b actual %b", $time,
						want.compressing, out_item.compressing);
					errors++;
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (stall_cycles < WATCHDOG) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: no request moved for %0d cycles", $time, WATCHDOG);
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		int       amp;
		int       burst_left;
		int       v;
		in_item_t item;
		thr_q = THR_RESET;
		ratio_q = RATIO_RESET;
		attack_q = ATTACK_RESET;
		release_q = RELEASE_RESET;
		envelope_q = '0;
		amp = 0;
		burst_left = 0;

		// While the envelope is still tiny every sample passes; with a zero threshold
		// and a ratio below one, clamped to one, gain is exactly one and the flag is set.
		directed_rows = '{
			sample_row(0, 1'b0, 1'b1, 1'b0),
			sample_row(32767, 1'b1, 1'b1, 1'b0),
			sample_row(-32768, 1'b0, 1'b1, 1'b0),
			sample_row(-1, 1'b0, 1'b1, 1'b0),
			sample_row(1, 1'b1, 1'b1, 1'b0),
			setting_row(16'd0, 16'd0, 16'hFFFF, 16'd0),
			sample_row(-32768, 1'b0, 1'b1, 1'b1),
			sample_row(32767, 1'b1, 1'b1, 1'b1),
			sample_row(0, 1'b0, 1'b1, 1'b1),
			sample_row(-12345, 1'b0, 1'b1, 1'b1),
			setting_row(16'd32767, 16'd1023, 16'hFFFF, 16'hFFFF),
			sample_row(-32768, 1'b0, 1'b0, 1'b0),
			sample_row(32767, 1'b0, 1'b0, 1'b0),
			sample_row(-32767, 1'b1, 1'b0, 1'b0),
			sample_row(16384, 1'b0, 1'b0, 1'b0),
			sample_row(-16384, 1'b0, 1'b0, 1'b0),
			sample_row(0, 1'b0, 1'b0, 1'b0),
			sample_row(32767, 1'b1, 1'b0, 1'b0),
			setting_row(16'd1, 16'd15, 16'd0, 16'd32768),
			sample_row(100, 1'b0, 1'b0, 1'b0),
			sample_row(-20000, 1'b0, 1'b0, 1'b0),
			sample_row(5, 1'b1, 1'b0, 1'b0),
			sample_row(0, 1'b0, 1'b0, 1'b0)
		};

		@(posedge arst_n);
		@(posedge clk);
		tx_idle_pct = 30;
		rx_idle_pct = 10;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SETTINGS) begin
				drain_results();
				write_settings(directed_rows[i].thr, directed_rows[i].ratio,
					directed_rows[i].attack, directed_rows[i].rel);
			end else begin
				offer_sample(directed_rows[i].item, directed_rows[i].known,
					directed_rows[i].compressing);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			write_settings(pick_setting(16'h0000, 16'hFFFF, 0, 4000),
				pick_setting(16'h0000, 16'hFFFF, 16, 200),
				pick_setting(16'h0000, 16'hFFFF, 1000, 65535),
				pick_setting(16'h0000, 16'hFFFF, 0, 8000));
			case ($urandom_range(0, 2))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 15;
				default: tx_idle_pct = 50;
			endcase
			case ($urandom_range(0, 2))
				0: rx_idle_pct = 0;
				1: rx_idle_pct = 5;
				default: rx_idle_pct = 20;
			endcase
			if (phase == PHASES - 1) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 1 && n == 40)
					rx_long_hold = 500;
				if (burst_left == 0) begin
					burst_left = $urandom_range(5, 60);
					case ($urandom_range(0, 3))
						0: amp = 32767;
						1: amp = 16384;
						2: amp = 2000;
						default: amp = 60;
					endcase
				end
				burst_left--;
				case ($urandom_range(0, 19))
					0: v = -32768;
					1: v = 32767;
					default: v = int'($urandom_range(0, 2 * amp)) - amp;
				endcase
				item.in_sample = v[15:0];
				item.block_last = ($urandom_range(0, 7) == 0);
				offer_sample(item, 1'b0, 1'b0);
			end
		end

		drain_results();
		repeat (80) @(posedge clk);
		$display("summary: %0d samples over %0d setting phases, %0d results checked,",
			samples_sent, PHASES + 3, results_checked);
		$display("summary: %0d of them compressed", compressed_seen);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
